>>> design/mstt_pkg.sv
// Shared types and constants for the multi-slot timeout timer.
package mstt_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SEL_W     = 4;
   localparam int CMP_W     = (SLOT_W > SEL_W) ? SLOT_W : SEL_W;
   localparam int LIMIT_W   = 16;
   localparam int COUNT_W   = 17;
   localparam int MASK_W    = 16;
   localparam int TIME_W    = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = 17'h1FFFF;
   localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = 16'd3;
   localparam logic [LIMIT_W-1:0] RESET_LIMIT   = 16'd5;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_ADD     = 3'd1;
   localparam logic [2:0] OP_REMOVE  = 3'd2;
   localparam logic [2:0] OP_RESTART = 3'd3;
   localparam logic [2:0] OP_QUERY   = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic [SEL_W-1:0]   slot;
      logic [LIMIT_W-1:0] timeout_limit;
      logic               start_now;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [SEL_W-1:0]   slot_index;
      logic               expired;
      logic [COUNT_W-1:0] count;
      logic [MASK_W-1:0]  expired_mask;
      logic [TIME_W-1:0]  system_time;
   } rsp_type;

   // Command token that walks the row of slot cells.
   typedef struct packed {
      logic               valid;
      logic [2:0]         op;
      logic [SEL_W-1:0]   slot;
      logic [LIMIT_W-1:0] timeout_limit;
      logic               start_now;
      logic               found;
      logic               ok;
      logic [SEL_W-1:0]   slot_index;
      logic               expired;
      logic [COUNT_W-1:0] count;
      logic [MASK_W-1:0]  expired_mask;
   } token_type;

endpackage

>>> design/mstt_cell.sv
// One timeout slot: holds its state and applies the passing command token.
module mstt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [mstt_pkg::SLOT_W-1:0] cell_id,
   input  mstt_pkg::token_type       tok_i,
   output mstt_pkg::token_type       tok_o
);
   import mstt_pkg::*;

   logic               valid_ff, valid_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;
   logic               running_ff, running_in;
   logic               expired_ff, expired_in;
   token_type          tok_ff, tok_in;

   logic               hit;
   logic               claim;
   logic               id_fits;
   logic               run_t;
   logic [COUNT_W-1:0] cnt_t;

   assign hit     = tok_i.valid && (CMP_W'(tok_i.slot) == CMP_W'(cell_id));
   assign claim   = tok_i.valid && (tok_i.op == OP_ADD) && !tok_i.found && !valid_ff;
   assign id_fits = (32'(cell_id) < 32'(MASK_W));

   // tick update: zero counter starts, running counts, past limit expires
   always_comb begin
      run_t = running_ff || (counter_ff == '0);
      cnt_t = counter_ff;
      if (run_t && (counter_ff < COUNT_MAX)) begin
         cnt_t = counter_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      limit_in   = limit_ff;
      counter_in = counter_ff;
      running_in = running_ff;
      expired_in = expired_ff;
      if (tok_i.valid) begin
         case (tok_i.op)
            OP_TICK: begin
               if (valid_ff && (limit_ff != '0)) begin
                  counter_in = cnt_t;
                  running_in = run_t;
                  if (run_t && (cnt_t > {1'b0, limit_ff})) begin
                     expired_in = 1'b1;
                     running_in = 1'b0;
                  end
               end
            end
            OP_ADD: begin
               if (claim) begin
                  valid_in   = 1'b1;
                  limit_in   = (tok_i.timeout_limit != '0) ? tok_i.timeout_limit
                                                           : DEFAULT_LIMIT;
                  expired_in = 1'b0;
                  counter_in = {1'b0, tok_i.timeout_limit};
                  running_in = tok_i.start_now;
               end
            end
            OP_REMOVE: begin
               if (hit && valid_ff) begin
                  valid_in   = 1'b0;
                  running_in = 1'b0;
                  expired_in = 1'b0;
               end
            end
            OP_RESTART: begin
               if (hit && valid_ff) begin
                  counter_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      tok_in = tok_i;
      if (claim) begin
         tok_in.found      = 1'b1;
         tok_in.ok         = 1'b1;
         tok_in.slot_index = SEL_W'(cell_id);
         tok_in.expired    = 1'b0;
         tok_in.count      = {1'b0, tok_i.timeout_limit};
      end else if (hit && (tok_i.op != OP_ADD)) begin
         if (tok_i.op inside {OP_REMOVE, OP_RESTART, OP_QUERY}) begin
            tok_in.ok = valid_ff;
         end
         tok_in.expired = valid_in ? expired_in : 1'b0;
         tok_in.count   = valid_in ? counter_in : '0;
      end
      if (id_fits) begin
         tok_in.expired_mask[SEL_W'(cell_id)] = expired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         limit_ff   <= RESET_LIMIT;
         counter_ff <= '0;
         running_ff <= 1'b0;
         expired_ff <= 1'b0;
         tok_ff     <= '0;
      end else begin
         valid_ff   <= valid_in;
         limit_ff   <= limit_in;
         counter_ff <= counter_in;
         running_ff <= running_in;
         expired_ff <= expired_in;
         tok_ff     <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

>>> design/multi_slot_timeout_timer_core.sv
// Top level of the multi-slot timeout timer: command entry, tick count, result.
//
// Usage: drive req_data and raise start; the command beat is taken at the
// rising edge where start is high and busy is low. Commands are tick, add,
// remove, restart and query. Each command yields exactly one result beat on
// rsp_data, marked by rsp_strobe for a single cycle; the receiver cannot
// stall it and must take it in that cycle.
// The command travels as a token down a row of NUM_SLOTS slot cells, one
// cell per cycle, each cell updating its own slot as the token passes.
// The result comes from the register of the last cell in that row.
// Busy drops in the result cycle, so a new command can be taken there;
// no new command is taken while one is still in the cell row.
// Reset: all slots free, limits 5, counters and flags zero, system time 0;
// the block accepts a command in the first cycle after reset.
module multi_slot_timeout_timer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mstt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mstt_pkg::rsp_type rsp_data
);
   import mstt_pkg::*;

   token_type         chain [NUM_SLOTS+1];
   logic              accept;
   logic              busy_ff, busy_in;
   logic [TIME_W-1:0] tick_ff, tick_in;

   assign accept = start && !busy;

   always_comb begin
      chain[0]               = '0;
      chain[0].valid         = accept;
      chain[0].op            = req_data.op;
      chain[0].slot          = req_data.slot;
      chain[0].timeout_limit = req_data.timeout_limit;
      chain[0].start_now     = req_data.start_now;
      chain[0].ok            = (req_data.op == OP_TICK);
      chain[0].slot_index    = (req_data.op == OP_ADD) ? '0 : req_data.slot;
   end

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      mstt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (SLOT_W'(g)),
         .tok_i   (chain[g]),
         .tok_o   (chain[g+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (chain[NUM_SLOTS].valid) begin
         busy_in = 1'b0;
      end
      tick_in = tick_ff;
      if (accept && (req_data.op == OP_TICK)) begin
         tick_in = tick_ff + TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tick_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         tick_ff <= tick_in;
      end
   end

   assign busy       = busy_ff && !chain[NUM_SLOTS].valid;
   assign rsp_strobe = chain[NUM_SLOTS].valid;

   always_comb begin
      rsp_data.ok           = chain[NUM_SLOTS].ok;
      rsp_data.slot_index   = chain[NUM_SLOTS].slot_index;
      rsp_data.expired      = chain[NUM_SLOTS].expired;
      rsp_data.count        = chain[NUM_SLOTS].count;
      rsp_data.expired_mask = chain[NUM_SLOTS].expired_mask;
      rsp_data.system_time  = tick_ff;
   end

endmodule
